FILE: hw/rtl/dtsv_pkg.sv
// shared types and constants of the date and time string validator
`timescale 1ns / 1ps
`default_nettype none
package dtsv_pkg;

	localparam int CHAR_W   = 8;
	localparam int STATUS_W = 2;
	localparam int FIRST_W  = 7;
	localparam int SECOND_W = 14;
	localparam int THIRD_W  = 27;
	localparam int POS_W    = 4;
	localparam int FIELD_W  = 2;
	localparam int DIGIT_W  = 4;
	localparam int MOD25_W  = 5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_VALID  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FORMAT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_MONTH  = 2'd3;

	// field kinds
	localparam logic KIND_DATE = 1'b0;
	localparam logic KIND_TIME = 1'b1;

	// characters
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	// field indexes
	localparam logic [FIELD_W-1:0] FLD_FIRST  = 2'd0;
	localparam logic [FIELD_W-1:0] FLD_SECOND = 2'd1;
	localparam logic [FIELD_W-1:0] FLD_THIRD  = 2'd2;

	// field end positions
	localparam logic [POS_W-1:0] LIM_FIRST     = 4'd2;
	localparam logic [POS_W-1:0] LIM_SECOND    = 4'd5;
	localparam logic [POS_W-1:0] LIM_DATE_LAST = 4'd10;
	localparam logic [POS_W-1:0] LIM_TIME_LAST = 4'd8;
	localparam logic [POS_W-1:0] POS_MAX       = 4'd11;

	// range limits
	localparam logic [FIRST_W-1:0]  DAY_MAX      = 7'd31;
	localparam logic [FIRST_W-1:0]  DAY_SHORT    = 7'd30;
	localparam logic [FIRST_W-1:0]  FEB_BASE     = 7'd28;
	localparam logic [FIRST_W-1:0]  HOUR_MAX     = 7'd23;
	localparam logic [SECOND_W-1:0] MINUTE_MAX   = 14'd59;
	localparam logic [THIRD_W-1:0]  SECOND_MAX   = 27'd59;
	localparam logic [SECOND_W-1:0] MONTH_MAX    = 14'd12;
	localparam logic [SECOND_W-1:0] MON_FEB      = 14'd2;
	localparam logic [SECOND_W-1:0] MON_APR      = 14'd4;
	localparam logic [SECOND_W-1:0] MON_JUN      = 14'd6;
	localparam logic [SECOND_W-1:0] MON_SEP      = 14'd9;
	localparam logic [SECOND_W-1:0] MON_NOV      = 14'd11;

	// values after one character step
	typedef struct packed {
		logic                bad;
		logic [FIRST_W-1:0]  first;
		logic [SECOND_W-1:0] second;
		logic [THIRD_W-1:0]  third;
		logic [MOD25_W-1:0]  third_mod25;
	} step_t;

endpackage
`default_nettype wire

FILE: hw/rtl/dtsv_if.sv
// request and result channel interfaces of the validator
`timescale 1ns / 1ps
`default_nettype none
interface dtsv_in_if;
	import dtsv_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last;
	modport source (output valid, char_code, last, input ready);
	modport sink (input valid, char_code, last, output ready);
endinterface

interface dtsv_out_if;
	import dtsv_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [FIRST_W-1:0]  first_value;
	logic [SECOND_W-1:0] second_value;
	logic [THIRD_W-1:0]  third_value;
	modport source (output valid, status, first_value, second_value, third_value,
		input ready);
	modport sink (input valid, status, first_value, second_value, third_value,
		output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/date_time_string_validator_core.sv
// top level: input register, parser, range check and result register
// a final character passes from the input register into the result register
// throughput: one character per cycle, set by the single input and result stage
// a final character waits in the input stage only while a verdict waits to be taken
// reset: arst_n clears the parse state, both stages and field_kind (date mode)
`timescale 1ns / 1ps
`default_nettype none
module date_time_string_validator_core
	import dtsv_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	dtsv_in_if.sink     char_ch,
	dtsv_out_if.source  result_ch
);

	// configuration: 0 date DD.MM.YYYY, 1 time HH:MM:SS
	logic field_kind_q;

	// input stage
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	// result stage
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [FIRST_W-1:0]  first_q;
	logic [SECOND_W-1:0] second_q;
	logic [THIRD_W-1:0]  third_q;

	logic                out_free;
	logic                advance;
	step_t               step;
	logic [STATUS_W-1:0] range_status;

	// result register can take a new verdict
	assign out_free = !out_valid_q || result_ch.ready;
	// non-final characters never wait on the result side
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign char_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_kind_q <= KIND_DATE;
		end else if (cfg_we) begin
			field_kind_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ch.ready) begin
			valid_s1 <= char_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ch.ready && char_ch.valid) begin
			char_s1 <= char_ch.char_code;
			last_s1 <= char_ch.last;
		end
	end

	// parse state advances once per character
	dtsv_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.kind      (field_kind_q),
		.char_code (char_s1),
		.last      (last_s1),
		.step      (step)
	);

	// range check on values after the final character
	dtsv_range u_range (
		.kind        (field_kind_q),
		.first       (step.first),
		.second      (step.second),
		.third       (step.third),
		.third_mod25 (step.third_mod25),
		.status      (range_status)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && last_s1;
		end
	end

	// format errors report zero values
	always_ff @(posedge clk) begin
		if (out_free && advance && last_s1) begin
			if (step.bad) begin
				status_q <= ST_FORMAT;
				first_q  <= '0;
				second_q <= '0;
				third_q  <= '0;
			end else begin
				status_q <= range_status;
				first_q  <= step.first;
				second_q <= step.second;
				third_q  <= step.third;
			end
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.status       = status_q;
	assign result_ch.first_value  = first_q;
	assign result_ch.second_value = second_q;
	assign result_ch.third_value  = third_q;

endmodule
`default_nettype wire

FILE: hw/rtl/dtsv_parser.sv
// per-character parse state: position, field, accumulators, format flag
`timescale 1ns / 1ps
`default_nettype none
module dtsv_parser
	import dtsv_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              kind,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic              last,
	output step_t                  step
);

	logic [POS_W-1:0]    pos_q;
	logic [FIELD_W-1:0]  field_q;
	logic [FIRST_W-1:0]  first_q;
	logic [SECOND_W-1:0] second_q;
	logic [THIRD_W-1:0]  third_q;
	logic [MOD25_W-1:0]  mod25_q;
	logic                bad_q;

	logic [POS_W-1:0]    lim;
	logic [POS_W-1:0]    lim_last;
	logic [POS_W-1:0]    pos_n;
	logic [FIELD_W-1:0]  field_n;
	logic [CHAR_W-1:0]   sep;
	logic [DIGIT_W-1:0]  digit;
	logic                is_digit;
	logic [7:0]          m25_sum;
	logic [13:0]         m25_prod;
	logic [3:0]          m25_quo;

	// x*10+d mod 25 on a value below 250, quotient by reciprocal 41/1024
	always_comb begin
		m25_sum  = 8'({mod25_q, 3'b000}) + 8'({mod25_q, 1'b0}) + 8'(digit);
		m25_prod = 14'(m25_sum) * 14'd41;
		m25_quo  = m25_prod[13:10];
	end

	always_comb begin
		lim_last = (kind == KIND_TIME) ? LIM_TIME_LAST : LIM_DATE_LAST;
		sep      = (kind == KIND_TIME) ? CH_COLON : CH_DOT;
		case (field_q)
			FLD_FIRST:  lim = LIM_FIRST;
			FLD_SECOND: lim = LIM_SECOND;
			default:    lim = lim_last;
		endcase
		is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		digit    = DIGIT_W'(char_code - CH_ZERO);

		step.bad         = bad_q;
		step.first       = first_q;
		step.second      = second_q;
		step.third       = third_q;
		step.third_mod25 = mod25_q;
		field_n          = field_q;

		if (!bad_q) begin
			if (pos_q < lim && char_code != CH_DOT) begin
				if (is_digit) begin
					case (field_q)
						FLD_FIRST: step.first = FIRST_W'({first_q, 3'b000})
							+ FIRST_W'({first_q, 1'b0}) + FIRST_W'(digit);
						FLD_SECOND: step.second = SECOND_W'({second_q, 3'b000})
							+ SECOND_W'({second_q, 1'b0}) + SECOND_W'(digit);
						default: begin
							step.third = THIRD_W'({third_q, 3'b000})
								+ THIRD_W'({third_q, 1'b0}) + THIRD_W'(digit);
							step.third_mod25 = MOD25_W'(m25_sum - 8'(m25_quo) * 8'd25);
						end
					endcase
				end else begin
					step.bad = 1'b1;
				end
			end else if (field_q < FLD_THIRD && char_code == sep) begin
				field_n = field_q + 2'd1;
			end else begin
				step.bad = 1'b1;
			end
		end

		pos_n = (pos_q < POS_MAX) ? pos_q + 4'd1 : pos_q;

		// implied end of string right after the last character
		if (last) begin
			if (field_n != FLD_THIRD || pos_n < lim_last) step.bad = 1'b1;
			if (pos_n > lim_last) step.bad = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			field_q  <= FLD_FIRST;
			first_q  <= '0;
			second_q <= '0;
			third_q  <= '0;
			mod25_q  <= '0;
			bad_q    <= 1'b0;
		end else if (en) begin
			if (last) begin
				pos_q    <= '0;
				field_q  <= FLD_FIRST;
				first_q  <= '0;
				second_q <= '0;
				third_q  <= '0;
				mod25_q  <= '0;
				bad_q    <= 1'b0;
			end else begin
				pos_q    <= pos_n;
				field_q  <= field_n;
				first_q  <= step.first;
				second_q <= step.second;
				third_q  <= step.third;
				mod25_q  <= step.third_mod25;
				bad_q    <= step.bad;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/dtsv_range.sv
// calendar and clock range check on parsed values
`timescale 1ns / 1ps
`default_nettype none
module dtsv_range
	import dtsv_pkg::*;
(
	input  wire logic                kind,
	input  wire logic [FIRST_W-1:0]  first,
	input  wire logic [SECOND_W-1:0] second,
	input  wire logic [THIRD_W-1:0]  third,
	input  wire logic [MOD25_W-1:0]  third_mod25,
	output logic      [STATUS_W-1:0] status
);

	logic               div4;
	logic               div16;
	logic               div25;
	logic               leap;
	logic [FIRST_W-1:0] feb_max;
	logic               short_month;

	always_comb begin
		div4        = (third[1:0] == 2'b00);
		div16       = (third[3:0] == 4'b0000);
		div25       = (third_mod25 == '0);
		// divisible by 100 is by 4 and 25, by 400 is by 16 and 25
		leap        = (div4 && !div25) || (div16 && div25);
		feb_max     = FEB_BASE + FIRST_W'(leap);
		short_month = (second == MON_APR) || (second == MON_JUN)
			|| (second == MON_SEP) || (second == MON_NOV);

		if (kind == KIND_TIME) begin
			status = (first > HOUR_MAX || second > MINUTE_MAX || third > SECOND_MAX)
				? ST_RANGE : ST_VALID;
		end else if (first > DAY_MAX) begin
			status = ST_RANGE;
		end else if (second == MON_FEB && first > feb_max) begin
			status = ST_RANGE;
		end else if (short_month && first > DAY_SHORT) begin
			status = ST_RANGE;
		end else if (second > MONTH_MAX) begin
			status = ST_MONTH;
		end else begin
			status = ST_VALID;
		end
	end

endmodule
`default_nettype wire
